[design/cidwl_pkg.sv]
`timescale 1ns / 1ps
package cidwl_pkg;

	localparam int MAX_CARDS = 32;
	localparam int NUM_W     = 56;
	localparam int RIGHTS_W  = 8;
	localparam int SLOT_W    = 5;
	localparam int COUNT_W   = 6;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_ENROLL = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [RIGHTS_W-1:0] RIGHTS_DENIED = 8'd0;
	localparam logic [RIGHTS_W-1:0] RIGHTS_ADMIN  = 8'd3;

	localparam logic [1:0] VERDICT_UNKNOWN = 2'd0;
	localparam logic [1:0] VERDICT_DENIED  = 2'd1;
	localparam logic [1:0] VERDICT_GRANTED = 2'd2;
	localparam logic [1:0] VERDICT_ADMIN   = 2'd3;

	typedef struct packed {
		logic [1:0]          op;
		logic [NUM_W-1:0]    card_number;
		logic [RIGHTS_W-1:0] rights;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         verdict;
		logic [SLOT_W-1:0]  slot;
		logic               table_full;
		logic [COUNT_W-1:0] entry_count;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_LOOKUP,
		CMD_ENROLL,
		CMD_CLEAR,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [NUM_W-1:0]    card_number;
		logic [RIGHTS_W-1:0] rights;
	} cmd_t;

	typedef struct packed {
		logic [NUM_W-1:0]    card_number;
		logic [RIGHTS_W-1:0] rights;
	} entry_t;

	function automatic logic [1:0] rights_verdict(input logic [RIGHTS_W-1:0] r);
		logic [1:0] v;
		if (r == RIGHTS_DENIED) begin
			v = VERDICT_DENIED;
		end else if (r == RIGHTS_ADMIN) begin
			v = VERDICT_ADMIN;
		end else begin
			v = VERDICT_GRANTED;
		end
		return v;
	endfunction

endpackage

[design/cidwl_front.sv]
`timescale 1ns / 1ps
module cidwl_front import cidwl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t item,
	output logic     cmd_valid,
	output cmd_t     cmd,
	input  logic     cmd_take
);

	// two-entry command queue between decode and execution
	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	cmd_t       decoded;
	logic       wr_en;
	logic       rd_en;

	always_comb begin
		decoded.card_number = item.card_number;
		decoded.rights      = item.rights;
		unique case (item.op)
			OP_LOOKUP: decoded.kind = CMD_LOOKUP;
			OP_ENROLL: decoded.kind = CMD_ENROLL;
			OP_CLEAR:  decoded.kind = CMD_CLEAR;
			default:   decoded.kind = CMD_NOP;
		endcase
	end

	assign full      = (fill_q == 2'd2);
	assign wr_en     = push && !full;
	assign cmd_valid = (fill_q != 2'd0);
	assign rd_en     = cmd_take && cmd_valid;
	assign cmd       = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= decoded;
		end
	end

endmodule

[design/cidwl_back.sv]
`timescale 1ns / 1ps
module cidwl_back import cidwl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  cmd_t      cmd,
	output logic      cmd_take,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t             state_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] iss_idx_q;
	logic [NUM_W-1:0]   num_q;
	logic               out_valid_q;
	out_item_t          out_q;
	logic               cmp_vld_s1;
	logic [SLOT_W-1:0]  cmp_idx_s1;
	entry_t             rd_entry_s1;

	entry_t             mem [MAX_CARDS];

	logic               rd_en;
	logic               wr_en;
	logic               has_room;
	logic               hit;
	logic               last;
	out_item_t          out_d;
	logic               out_load;
	logic               out_set;

	assign cmd_take = (state_q == ST_IDLE) && cmd_valid && (!out_valid_q || pop);
	assign has_room = (count_q < COUNT_W'(MAX_CARDS));
	assign wr_en    = cmd_take && (cmd.kind == CMD_ENROLL) && has_room;
	assign rd_en    = (state_q == ST_SCAN) && (iss_idx_q < count_q);
	assign hit      = cmp_vld_s1 && (rd_entry_s1.card_number == num_q);
	assign last     = cmp_vld_s1 && ((COUNT_W'(cmp_idx_s1) + COUNT_W'(1)) == count_q);

	assign empty  = !out_valid_q;
	assign result = out_q;

	// next result word; a lookup loads its miss answer when taken
	always_comb begin
		out_d    = out_q;
		out_load = 1'b0;
		out_set  = 1'b0;
		if (state_q == ST_IDLE) begin
			out_d = '{verdict: VERDICT_UNKNOWN, slot: '0,
				table_full: 1'b0, entry_count: count_q};
			if (cmd_take) begin
				out_load = 1'b1;
				unique case (cmd.kind)
					CMD_LOOKUP: begin
						out_set = (count_q == '0);
					end
					CMD_ENROLL: begin
						out_set = 1'b1;
						if (has_room) begin
							out_d.slot        = count_q[SLOT_W-1:0];
							out_d.entry_count = count_q + COUNT_W'(1);
						end else begin
							out_d.table_full = 1'b1;
						end
					end
					CMD_CLEAR: begin
						out_set           = 1'b1;
						out_d.entry_count = '0;
					end
					default: begin
						out_set = 1'b1;
					end
				endcase
			end
		end else begin
			// the output register was drained when this lookup was taken
			out_set = hit || last;
			if (hit) begin
				out_load      = 1'b1;
				out_d.verdict = rights_verdict(rd_entry_s1.rights);
				out_d.slot    = cmp_idx_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[SLOT_W-1:0]] <= '{card_number: cmd.card_number, rights: cmd.rights};
		end
		if (rd_en) begin
			rd_entry_s1 <= mem[iss_idx_q[SLOT_W-1:0]];
			cmp_idx_s1  <= iss_idx_q[SLOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			iss_idx_q   <= '0;
			num_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			cmp_vld_s1  <= 1'b0;
		end else begin
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_q <= out_d;
			end
			unique case (state_q)
				ST_IDLE: begin
					cmp_vld_s1 <= 1'b0;
					if (cmd_take) begin
						unique case (cmd.kind)
							CMD_LOOKUP: begin
								if (count_q != '0) begin
									num_q     <= cmd.card_number;
									iss_idx_q <= '0;
									state_q   <= ST_SCAN;
								end
							end
							CMD_ENROLL: begin
								if (has_room) begin
									count_q <= count_q + COUNT_W'(1);
								end
							end
							CMD_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (hit || last) begin
						cmp_vld_s1 <= 1'b0;
						state_q    <= ST_IDLE;
					end else begin
						cmp_vld_s1 <= rd_en;
						if (rd_en) begin
							iss_idx_q <= iss_idx_q + COUNT_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(MAX_CARDS))
		else $error("entry count above table size");

	a_scan_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !out_valid_q)
		else $error("result register busy during scan");

	a_cmp_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_s1 |-> (state_q == ST_SCAN))
		else $error("compare stage live outside scan");

	a_hit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.verdict != VERDICT_UNKNOWN))
		|-> (COUNT_W'(out_q.slot) < out_q.entry_count))
		else $error("lookup hit slot beyond entry count");

	a_no_take_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !cmd_take)
		else $error("command taken during scan");

endmodule

[design/card_id_whitelist_lookup.sv]
`timescale 1ns / 1ps
// Enroll, clear, unused ops and a lookup on an empty table: result registered when taken.
// Lookup: the scan checks entries in order and ends at the first hit or after the last one;
// the scan reads one entry per cycle from the registered memory port.
// Throughput, with pop high: one short op per cycle; a lookup holds the back end until its
// scan ends while a two-entry command queue keeps taking transfers.
// Reset clears the entry count and both queues; table contents stay undefined.
module card_id_whitelist_lookup import cidwl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_take;

	cidwl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	cidwl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

[dv/tb_card_id_whitelist_lookup.sv]
`timescale 1ns / 1ps
module tb_card_id_whitelist_lookup;
	import cidwl_pkg::*;

	localparam logic [1:0] OP_UNUSED    = 2'd3;
	localparam int         TOTAL_ITEMS  = 1750;
	localparam int         IDLE_PCT     = 18;
	localparam int         QUIET_LIMIT  = 4000;
	localparam int         SETTLE_TICKS = MAX_CARDS + 8;

	class card_table_scoreboard;
		logic [NUM_W-1:0]    stored_ids[MAX_CARDS];
		logic [RIGHTS_W-1:0] stored_rights[MAX_CARDS];
		int                  enrolled;
		out_item_t           expected_replies[$];
		int                  mismatches;
		int                  checked;
		int                  hits;
		int                  misses;
		int                  refused;
		int                  clears;

		function new();
			enrolled   = 0;
			mismatches = 0;
			checked    = 0;
			hits       = 0;
			misses     = 0;
			refused    = 0;
			clears     = 0;
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction

		task report_mismatch(input string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			mismatches++;
		endtask

		// predict the reply for one accepted transfer and update the table copy
		task note_card_op(input in_item_t it);
			out_item_t want;
			bit        found;
			want  = '0;
			found = 1'b0;
			case (it.op)
				OP_LOOKUP: begin
					// first matching entry wins
					for (int k = 0; k < enrolled; k++) begin
						if (!found && stored_ids[k] == it.card_number) begin
							found     = 1'b1;
							want.slot = k[SLOT_W-1:0];
							if (stored_rights[k] == RIGHTS_DENIED) begin
								want.verdict = VERDICT_DENIED;
							end else if (stored_rights[k] == RIGHTS_ADMIN) begin
								want.verdict = VERDICT_ADMIN;
							end else begin
								want.verdict = VERDICT_GRANTED;
							end
						end
					end
					if (found) begin
						hits++;
					end else begin
						misses++;
					end
				end
				OP_ENROLL: begin
					if (enrolled >= MAX_CARDS) begin
						want.table_full = 1'b1;
						refused++;
					end else begin
						stored_ids[enrolled]    = it.card_number;
						stored_rights[enrolled] = it.rights;
						want.slot               = enrolled[SLOT_W-1:0];
						enrolled++;
					end
				end
				OP_CLEAR: begin
					enrolled = 0;
					clears++;
				end
				default: ;
			endcase
			want.entry_count = enrolled[COUNT_W-1:0];
			expected_replies.push_back(want);
		endtask

		task check_card_reply(input out_item_t got);
			out_item_t want;
			if (expected_replies.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
			end else begin
				want = expected_replies.pop_front();
				checked++;
				if (got.verdict !== want.verdict) begin
					report_mismatch($sformatf("verdict got %0d want %0d",
						got.verdict, want.verdict));
				end
				if (got.slot !== want.slot) begin
					report_mismatch($sformatf("slot got %0d want %0d", got.slot, want.slot));
				end
				if (got.table_full !== want.table_full) begin
					report_mismatch($sformatf("table_full got %0b want %0b",
						got.table_full, want.table_full));
				end
				if (got.entry_count !== want.entry_count) begin
					report_mismatch($sformatf("entry_count got %0d want %0d",
						got.entry_count, want.entry_count));
				end
			end
		endtask

		task flush_leftovers();
			if (expected_replies.size() != 0) begin
				report_mismatch($sformatf("%0d results never arrived", expected_replies.size()));
			end
		endtask
	endclass

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      push   = 1'b0;
	logic      full;
	in_item_t  item   = '0;
	logic      empty;
	logic      pop    = 1'b0;
	out_item_t result;

	logic calm = 1'b0;
	int   quiet_cycles = 0;
	int   items_sent = 0;

	logic [NUM_W-1:0] enrolled_ids[$];
	card_table_scoreboard sb = new();

	card_id_whitelist_lookup dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// both transfers are sampled with the values that stood before the edge
	always @(posedge clk) begin
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (push && !full) begin
				sb.note_card_op(item);
				moved = 1'b1;
			end
			if (pop && !empty) begin
				sb.check_card_reply(result);
				moved = 1'b1;
			end
		end
		quiet_cycles <= moved ? 0 : quiet_cycles + 1;
	end

	always @(posedge clk) begin
		pop <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("no transfer for %0d cycles", QUIET_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic send_item(input in_item_t it);
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			push <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < IDLE_PCT) @(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_op(input logic [1:0] op, input logic [NUM_W-1:0] num,
		input logic [RIGHTS_W-1:0] r);
		in_item_t it;
		it.op          = op;
		it.card_number = num;
		it.rights      = r;
		if (op == OP_ENROLL && enrolled_ids.size() < MAX_CARDS) begin
			enrolled_ids.push_back(num);
		end else if (op == OP_CLEAR) begin
			enrolled_ids.delete();
		end
		send_item(it);
	endtask

	task automatic hold_until_drained();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic random_card_op();
		logic [63:0]         wide;
		logic [NUM_W-1:0]    num;
		logic [RIGHTS_W-1:0] r;
		logic [1:0]          op;
		int                  pick;
		wide = {$urandom(), $urandom()};
		num  = wide[NUM_W-1:0];
		pick = $urandom_range(9);
		if (pick < 3) begin
			r = RIGHTS_DENIED;
		end else if (pick < 6) begin
			r = RIGHTS_ADMIN;
		end else begin
			r = RIGHTS_W'($urandom_range(255));
		end
		pick = $urandom_range(99);
		if (pick < 2) begin
			op = OP_UNUSED;
		end else if (pick < 3) begin
			op = OP_CLEAR;
		end else if (pick < 40) begin
			op = OP_ENROLL;
			if (enrolled_ids.size() > 0 && $urandom_range(6) == 0) begin
				num = enrolled_ids[$urandom_range(enrolled_ids.size() - 1)];
			end
		end else begin
			op   = OP_LOOKUP;
			pick = $urandom_range(99);
			if (enrolled_ids.size() > 0 && pick < 75) begin
				num = enrolled_ids[$urandom_range(enrolled_ids.size() - 1)];
				// near miss: one bit off a known card
				if (pick >= 60) begin
					num = num ^ ({{(NUM_W-1){1'b0}}, 1'b1} << $urandom_range(NUM_W - 1));
				end
			end
		end
		send_op(op, num, r);
	endtask

	initial begin : stimulus
		int ep_len;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, unused op, extremes of number and rights
		send_op(OP_LOOKUP, {NUM_W{1'b1}}, 8'hFF);
		send_op(OP_UNUSED, {NUM_W{1'b1}}, 8'hFF);
		send_op(OP_ENROLL, '0, RIGHTS_DENIED);
		send_op(OP_ENROLL, {NUM_W{1'b1}}, RIGHTS_ADMIN);
		send_op(OP_ENROLL, {7{8'h55}}, 8'hFF);
		send_op(OP_ENROLL, {7{8'h3C}}, 8'h01);
		send_op(OP_ENROLL, {7{8'h3C}}, RIGHTS_DENIED);
		send_op(OP_ENROLL, {7{8'hC3}}, 8'h80);
		send_op(OP_LOOKUP, '0, 8'h00);
		send_op(OP_LOOKUP, {NUM_W{1'b1}}, 8'h00);
		send_op(OP_LOOKUP, {7{8'h55}}, 8'h00);
		send_op(OP_LOOKUP, {7{8'h3C}}, 8'h00);
		send_op(OP_LOOKUP, {7{8'hC3}}, 8'h00);
		send_op(OP_LOOKUP, {7{8'hAA}}, 8'h00);
		send_op(OP_LOOKUP, {1'b0, {(NUM_W-1){1'b1}}}, 8'h00);
		send_op(OP_LOOKUP, {{(NUM_W-1){1'b0}}, 1'b1}, 8'h00);
		send_op(OP_UNUSED, '0, 8'h00);
		send_op(OP_CLEAR, {7{8'hAA}}, 8'hAA);
		send_op(OP_LOOKUP, {NUM_W{1'b1}}, 8'h00);
		send_op(OP_LOOKUP, '0, 8'h00);
		send_op(OP_CLEAR, '0, 8'h00);
		hold_until_drained();

		// episodes start from an empty table; long ones can overflow it
		while (items_sent < TOTAL_ITEMS) begin
			calm <= (items_sent >= 700 && items_sent < 1000);
			if ($urandom_range(3) == 0) begin
				hold_until_drained();
			end
			send_op(OP_CLEAR, '0, 8'h00);
			ep_len = ($urandom_range(3) == 0) ? $urandom_range(5, 30) : $urandom_range(40, 140);
			repeat (ep_len) random_card_op();
		end
		push <= 1'b0;
		calm <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
		sb.flush_leftovers();

		$display("%0d transfers in, %0d results checked", items_sent, sb.checked);
		$display("lookups: %0d hits, %0d misses; %0d enrolls refused on a full table; %0d clears",
			sb.hits, sb.misses, sb.refused, sb.clears);
		if (sb.mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
